// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define GBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define GBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gbe_pkg.sv -----
// Shared widths and constants of the Gabriel edge tester.
package gbe_pkg;

  localparam int IDX_IN_W   = 8;
  localparam int COORD_IN_W = 10;
  localparam int CFG_W      = 9;
  localparam int DIST_W     = 15;
  localparam int FRAC_BITS  = 4;

  localparam int GBE_MAX_POINTS = 256;
  localparam int GBE_COORD_BITS = 10;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

// ----- rtl/core/gbe_point_store.sv -----
// Point memory: one write port and one registered read port.
module gbe_point_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 20
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Writes happen only while the controller is idle and reads only during a
  // request, so the two ports never touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/gbe_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module gbe_sqrt #(
  parameter int ROOT_W = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_r, rad_nxt;
  logic [ROOT_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic [ROOT_W+1:0]   diff;

  // Bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rad_nxt = {rad_r[2*ROOT_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        // The last remainder is never used, so dropping its top bits is safe.
        rem_nxt  = diff[ROOT_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[ROOT_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/core/gabriel_edge_tester.sv -----
// Load request: written in the accept cycle, busy never rises. Query with a bad or equal index:
// result strobe in the cycle after accept, busy never rises. Valid query of two distinct points:
// result after the states RD_A, RD_B, CAPB, SUM, the point scan (one memory read per cycle),
// DRAIN and the bit-serial square root in ROOT.
// The receiver cannot stall; one request is worked on at a time while busy is high.
// Reset (synchronous, active low) clears control state and point_count; point memory is not cleared.
module gabriel_edge_tester
  import gbe_pkg::*;
#(
  parameter int MAX_POINTS = GBE_MAX_POINTS,
  parameter int COORD_BITS = GBE_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [IDX_IN_W-1:0]   in_first_index,
  input  logic [COORD_IN_W-1:0] in_x_coord,
  input  logic [COORD_IN_W-1:0] in_y_coord,
  input  logic [IDX_IN_W-1:0]   in_second_index,
  output logic                  out_valid,
  output logic [IDX_IN_W-1:0]   out_pair_first,
  output logic [IDX_IN_W-1:0]   out_pair_second,
  output logic [DIST_W-1:0]     out_distance_value,
  output logic                  out_is_edge,
  output logic                  out_index_error
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int D2_W   = SQ_W + 1;
  localparam int EX_W   = COORD_BITS + 1;
  localparam int ESQ_W  = 2 * EX_W;
  localparam int E2_W   = ESQ_W + 1;
  localparam int ROOT_W = COORD_BITS + FRAC_BITS + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SAT_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD_A  = 3'd1;
  localparam logic [2:0] ST_RD_B  = 3'd2;
  localparam logic [2:0] ST_CAPB  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;
  localparam logic [2:0] ST_ROOT  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [CFG_W-1:0]      point_count_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      cnt_eff;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [IDX_IN_W-1:0]   a_r, b_r;
  logic                  edge_r, edge_nxt;
  logic                  p1_v_r, p1_v_nxt;
  logic                  p1_skip_r;
  logic                  p2_v_r;
  logic                  p2_skip_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_IN_W-1:0]   out_first_r, out_second_r;
  logic [DIST_W-1:0]     out_dist_r;
  logic                  out_edge_r, out_err_r;

  logic                  accept;
  logic                  query_bad;
  logic                  load_ok;
  logic                  mem_wr_en;
  logic                  mem_rd_en;
  logic [IDX_W-1:0]      mem_rd_addr;
  logic [PT_W-1:0]       mem_wr_data;
  logic [PT_W-1:0]       mem_rd_data;
  logic [COORD_BITS-1:0] xk, yk;
  logic [COORD_BITS-1:0] xi_r, yi_r;
  logic [COORD_BITS-1:0] adx, ady;
  logic [SQ_W-1:0]       dx2_r, dy2_r;
  logic [D2_W-1:0]       d2_r;
  logic [EX_W-1:0]       sx_r, sy_r;
  logic [EX_W-1:0]       tx, ty, ex_abs, ey_abs;
  logic [ESQ_W-1:0]      ex2, ey2, ex2_r, ey2_r;
  logic [E2_W-1:0]       e2;
  logic                  inside_hit;
  logic                  sq_start, sq_done;
  logic [ROOT_W-1:0]     sq_root;
  logic [DIST_W-1:0]     dist_sat;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;

  // A count above the store size acts as the store size.
  assign cnt_eff = (CW'(point_count_r) > CW'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : CNT_W'(point_count_r);
  assign query_bad = (CW'(in_first_index) >= CW'(cnt_eff)) ||
                     (CW'(in_second_index) >= CW'(cnt_eff));
  assign load_ok   = (CW'(in_first_index) < CW'(MAX_POINTS));

  assign mem_wr_data = {COORD_BITS'(in_x_coord), COORD_BITS'(in_y_coord)};

  gbe_point_store #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (IDX_W),
    .DATA_W (PT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (IDX_W'(in_first_index)),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign xk = mem_rd_data[PT_W-1 -: COORD_BITS];
  assign yk = mem_rd_data[COORD_BITS-1:0];

  // Pair geometry once point j arrives from memory.
  assign adx = (xi_r >= xk) ? (xi_r - xk) : (xk - xi_r);
  assign ady = (yi_r >= yk) ? (yi_r - yk) : (yk - yi_r);

  // Scan stage one: offset of doubled point k from the doubled circle center, squared.
  assign tx     = {xk, 1'b0};
  assign ty     = {yk, 1'b0};
  assign ex_abs = (tx >= sx_r) ? (tx - sx_r) : (sx_r - tx);
  assign ey_abs = (ty >= sy_r) ? (ty - sy_r) : (sy_r - ty);
  assign ex2    = ex_abs * ex_abs;
  assign ey2    = ey_abs * ey_abs;

  // Scan stage two: strictly inside the circle on the pair.
  assign e2         = E2_W'(ex2_r) + E2_W'(ey2_r);
  assign inside_hit = p2_v_r && !p2_skip_r && (e2 < E2_W'(d2_r));

  gbe_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (RAD_W'({d2_r, {(2 * FRAC_BITS){1'b0}}})),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign dist_sat = (SAT_W'(sq_root) > SAT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sq_root);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    edge_nxt      = edge_r;
    p1_v_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    sq_start      = 1'b0;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = IDX_W'(a_r);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_mode) begin
            mem_wr_en = load_ok;
          end else if (query_bad || (in_first_index == in_second_index)) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        mem_rd_en = 1'b1;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = IDX_W'(b_r);
        state_nxt   = ST_CAPB;
      end
      ST_CAPB: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        edge_nxt  = 1'b1;
        k_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = k_r[IDX_W-1:0];
        p1_v_nxt    = 1'b1;
        k_nxt       = k_r + 1'b1;
        if (k_r == count_r - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          sq_start  = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (inside_hit) begin
      edge_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      point_count_r <= '0;
      p1_v_r        <= 1'b0;
      p2_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p1_v_r;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        point_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    edge_r    <= edge_nxt;
    p1_skip_r <= (CW'(k_r) == CW'(a_r)) || (CW'(k_r) == CW'(b_r));
    p2_skip_r <= p1_skip_r;
    ex2_r     <= ex2;
    ey2_r     <= ey2;
    if (accept) begin
      a_r     <= in_first_index;
      b_r     <= in_second_index;
      count_r <= cnt_eff;
    end
    if (state_r == ST_RD_B) begin
      xi_r <= xk;
      yi_r <= yk;
    end
    if (state_r == ST_CAPB) begin
      dx2_r <= adx * adx;
      dy2_r <= ady * ady;
      sx_r  <= EX_W'(xi_r) + EX_W'(xk);
      sy_r  <= EX_W'(yi_r) + EX_W'(yk);
    end
    if (state_r == ST_SUM) begin
      d2_r <= D2_W'(dx2_r) + D2_W'(dy2_r);
    end
    if (accept && in_mode) begin
      out_first_r  <= in_first_index;
      out_second_r <= in_second_index;
      out_dist_r   <= '0;
      out_edge_r   <= 1'b0;
      out_err_r    <= query_bad;
    end else if ((state_r == ST_ROOT) && sq_done) begin
      out_first_r  <= a_r;
      out_second_r <= b_r;
      out_dist_r   <= dist_sat;
      out_edge_r   <= edge_r;
      out_err_r    <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pair_first     = out_first_r;
  assign out_pair_second    = out_second_r;
  assign out_distance_value = out_dist_r;
  assign out_is_edge        = out_edge_r;
  assign out_index_error    = out_err_r;

endmodule

// ----- rtl/core/gbe_checker.sv -----
// Port-level checker for the Gabriel edge tester and its bind statement.
`include "assert_macros.svh"

module gbe_checker
  import gbe_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_mode,
  input logic                  out_valid,
  input logic [IDX_IN_W-1:0]   out_pair_first,
  input logic [IDX_IN_W-1:0]   out_pair_second,
  input logic [DIST_W-1:0]     out_distance_value,
  input logic                  out_is_edge,
  input logic                  out_index_error
);

  // A result always comes with the block ready for the next request.
  `GBE_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while busy")

  // A load produces no result and never makes the block busy.
  `GBE_ASSERT_NEXT(a_load_quiet, start && !busy && !in_mode, !out_valid && !busy,
                   "load request produced a result or busy")

  // A query either answers at once or holds busy.
  `GBE_ASSERT_NEXT(a_query_progress, start && !busy && in_mode, out_valid || busy,
                   "query request neither answered nor busy")

  `GBE_ASSERT_NOW(a_error_clean, out_valid && out_index_error,
                  (out_distance_value == '0) && !out_is_edge,
                  "index error result carries distance or edge")

  `GBE_ASSERT_NOW(a_same_point, out_valid && !out_index_error &&
                  (out_pair_first == out_pair_second),
                  (out_distance_value == '0) && !out_is_edge,
                  "same-point query reported distance or edge")

endmodule

bind gabriel_edge_tester gbe_checker u_gbe_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_mode            (in_mode),
  .out_valid          (out_valid),
  .out_pair_first     (out_pair_first),
  .out_pair_second    (out_pair_second),
  .out_distance_value (out_distance_value),
  .out_is_edge        (out_is_edge),
  .out_index_error    (out_index_error)
);

// ----- tb/gabriel_edge_checker.sv -----
// Watches the request and answer channels of the Gabriel edge tester, predicts and compares.
`timescale 1ns / 1ps

module gabriel_edge_checker
  import gbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_mode,
  input  logic [IDX_IN_W-1:0]   in_first_index,
  input  logic [COORD_IN_W-1:0] in_x_coord,
  input  logic [COORD_IN_W-1:0] in_y_coord,
  input  logic [IDX_IN_W-1:0]   in_second_index,
  input  logic                  out_valid,
  input  logic [IDX_IN_W-1:0]   out_pair_first,
  input  logic [IDX_IN_W-1:0]   out_pair_second,
  input  logic [DIST_W-1:0]     out_distance_value,
  input  logic                  out_is_edge,
  input  logic                  out_index_error,
  output int                    mismatches,
  output int                    pending,
  output int                    answers_checked,
  output int                    edges_seen
);

  localparam logic MODE_LOAD = 1'b0;

  typedef struct packed {
    logic [IDX_IN_W-1:0] pair_first;
    logic [IDX_IN_W-1:0] pair_second;
    logic [DIST_W-1:0]   distance_value;
    logic                is_edge;
    logic                index_error;
  } gabriel_answer_t;

  logic [GBE_COORD_BITS-1:0] pt_x [GBE_MAX_POINTS];
  logic [GBE_COORD_BITS-1:0] pt_y [GBE_MAX_POINTS];
  logic [CFG_W-1:0]          active_count = '0;
  gabriel_answer_t           answer_queue [$];
  gabriel_answer_t           want;
  gabriel_answer_t           got;
  int                        mismatch_count = 0;
  int                        checked_count = 0;
  int                        edge_count = 0;
  int                        queue_depth = 0;

  assign mismatches      = mismatch_count;
  assign pending         = queue_depth;
  assign answers_checked = checked_count;
  assign edges_seen      = edge_count;

  // Distance times 16, truncated: the largest root whose square fits under d2 * 256.
  function automatic logic [DIST_W-1:0] fixed_distance(longint unsigned sq);
    longint unsigned scaled;
    longint unsigned root;
    longint unsigned trial;
    int              b;
    scaled = sq << (2 * FRAC_BITS);
    root = 0;
    for (b = DIST_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    if (root > DIST_MAX) root = DIST_MAX;
    return root[DIST_W-1:0];
  endfunction

  function automatic gabriel_answer_t answer_query(logic [IDX_IN_W-1:0] a,
                                                   logic [IDX_IN_W-1:0] b);
    gabriel_answer_t ans;
    int              limit;
    int              k;
    longint          xi, yi, xj, yj, xk, yk, dx, dy, ex, ey;
    longint unsigned d2, e2;
    limit = (active_count > GBE_MAX_POINTS) ? GBE_MAX_POINTS : active_count;
    ans.pair_first     = a;
    ans.pair_second    = b;
    ans.distance_value = '0;
    ans.is_edge        = 1'b0;
    ans.index_error    = 1'b0;
    if (a >= limit || b >= limit) begin
      ans.index_error = 1'b1;
    end else if (a != b) begin
      xi = pt_x[a];
      yi = pt_y[a];
      xj = pt_x[b];
      yj = pt_y[b];
      dx = xi - xj;
      dy = yi - yj;
      d2 = dx * dx + dy * dy;
      ans.distance_value = fixed_distance(d2);
      // A point strictly inside the circle on the pair breaks the edge; the boundary does not.
      ans.is_edge = 1'b1;
      for (k = 0; k < limit; k++) begin
        if (k != a && k != b) begin
          xk = pt_x[k];
          yk = pt_y[k];
          ex = 2 * xk - xi - xj;
          ey = 2 * yk - yi - yj;
          e2 = ex * ex + ey * ey;
          if (e2 < d2) ans.is_edge = 1'b0;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      active_count = '0;
    end else begin
      // Answers leave before new requests are taken, so an answer never matches its own cycle.
      if (out_valid) begin
        got = {out_pair_first, out_pair_second, out_distance_value, out_is_edge,
               out_index_error};
        if (out_is_edge) edge_count++;
        if (answer_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected answer at %0t: first=%0d second=%0d dist=%0d edge=%0b err=%0b",
                     $time, got.pair_first, got.pair_second, got.distance_value,
                     got.is_edge, got.index_error);
        end else begin
          want = answer_queue.pop_front();
          checked_count++;
          if (got.pair_first !== want.pair_first || got.pair_second !== want.pair_second ||
              got.distance_value !== want.distance_value || got.is_edge !== want.is_edge ||
              got.index_error !== want.index_error) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Answer mismatch at %0t:", $time);
              $display("  expected first=%0d second=%0d dist=%0d edge=%0b err=%0b",
                       want.pair_first, want.pair_second, want.distance_value,
                       want.is_edge, want.index_error);
              $display("  actual   first=%0d second=%0d dist=%0d edge=%0b err=%0b",
                       got.pair_first, got.pair_second, got.distance_value,
                       got.is_edge, got.index_error);
            end
          end
        end
      end
      if (cfg_wr_en) active_count = cfg_wr_data;
      if (start && !busy) begin
        if (in_mode == MODE_LOAD) begin
          if (in_first_index < GBE_MAX_POINTS) begin
            pt_x[in_first_index] = in_x_coord[GBE_COORD_BITS-1:0];
            pt_y[in_first_index] = in_y_coord[GBE_COORD_BITS-1:0];
          end
        end else begin
          answer_queue.push_back(answer_query(in_first_index, in_second_index));
        end
      end
      queue_depth = answer_queue.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the Gabriel edge tester regression: clock, reset, requests, configuration and verdict.
`timescale 1ns / 1ps

module testbench;
  import gbe_pkg::*;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_QUERY   = 1'b1;
  localparam int   DRAIN_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_mode = MODE_LOAD;
  logic [IDX_IN_W-1:0]   in_first_index = '0;
  logic [COORD_IN_W-1:0] in_x_coord = '0;
  logic [COORD_IN_W-1:0] in_y_coord = '0;
  logic [IDX_IN_W-1:0]   in_second_index = '0;
  logic                  out_valid;
  logic [IDX_IN_W-1:0]   out_pair_first;
  logic [IDX_IN_W-1:0]   out_pair_second;
  logic [DIST_W-1:0]     out_distance_value;
  logic                  out_is_edge;
  logic                  out_index_error;

  int mismatch_total;
  int pending_answers;
  int answers_total;
  int edges_total;
  int sender_idle_pct = 0;
  int load_total = 0;
  int query_total = 0;
  int settings_total = 0;

  always #4 clk = ~clk;

  gabriel_edge_tester uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_first_index     (in_first_index),
    .in_x_coord         (in_x_coord),
    .in_y_coord         (in_y_coord),
    .in_second_index    (in_second_index),
    .out_valid          (out_valid),
    .out_pair_first     (out_pair_first),
    .out_pair_second    (out_pair_second),
    .out_distance_value (out_distance_value),
    .out_is_edge        (out_is_edge),
    .out_index_error    (out_index_error)
  );

  gabriel_edge_checker answer_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_first_index     (in_first_index),
    .in_x_coord         (in_x_coord),
    .in_y_coord         (in_y_coord),
    .in_second_index    (in_second_index),
    .out_valid          (out_valid),
    .out_pair_first     (out_pair_first),
    .out_pair_second    (out_pair_second),
    .out_distance_value (out_distance_value),
    .out_is_edge        (out_is_edge),
    .out_index_error    (out_index_error),
    .mismatches         (mismatch_total),
    .pending            (pending_answers),
    .answers_checked    (answers_total),
    .edges_seen         (edges_total)
  );

  // Presents one request, after random idle cycles, and returns at the edge that takes it.
  task automatic send_request(input logic mode, input logic [IDX_IN_W-1:0] a,
                              input logic [COORD_IN_W-1:0] x, input logic [COORD_IN_W-1:0] y,
                              input logic [IDX_IN_W-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_first_index  <= a;
    in_x_coord      <= x;
    in_y_coord      <= y;
    in_second_index <= b;
    do @(posedge clk); while (busy);
    if (mode == MODE_LOAD) load_total++;
    else query_total++;
  endtask

  task automatic load_point(input int slot, input int x, input int y);
    send_request(MODE_LOAD, IDX_IN_W'(slot), COORD_IN_W'(x), COORD_IN_W'(y),
                 IDX_IN_W'($urandom_range(255)));
  endtask

  task automatic query_pair(input int a, input int b);
    send_request(MODE_QUERY, IDX_IN_W'(a), COORD_IN_W'($urandom_range(1023)),
                 COORD_IN_W'($urandom_range(1023)), IDX_IN_W'(b));
  endtask

  // The count register only changes once every answer is in and the block is idle.
  task automatic set_point_count(input int value);
    start <= 1'b0;
    do @(negedge clk); while (pending_answers != 0 || busy);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_total++;
  endtask

  task automatic run_phase(input int idle_pct, input int blocks);
    int blk, count, limit, lo, span, n_items, i, r, a, b, slot;
    sender_idle_pct = idle_pct;
    for (blk = 0; blk < blocks; blk++) begin
      case (blk)
        0: count = 511;
        1: count = GBE_MAX_POINTS;
        default: begin
          r = $urandom_range(15);
          if (r == 0) count = 0;
          else if (r == 1) count = 1;
          else if (r == 2) count = $urandom_range(257, 511);
          else if (r == 3) count = 255;
          else count = $urandom_range(2, 12);
        end
      endcase
      set_point_count(count);
      limit = (count > GBE_MAX_POINTS) ? GBE_MAX_POINTS : count;
      // Large sets scan every point per query, so those blocks stay short.
      n_items = (limit > 32) ? 10 : 22;
      // A narrow coordinate window makes coincident points and boundary hits likely.
      if ($urandom_range(1)) begin
        lo = 0;
        span = 1023;
      end else begin
        span = $urandom_range(3, 40);
        lo = $urandom_range(1023 - span);
      end
      for (i = 0; i < n_items; i++) begin
        r = $urandom_range(99);
        if (r < 25) begin
          if (limit > 0 && $urandom_range(3) != 0) slot = $urandom_range(limit - 1);
          else slot = $urandom_range(255);
          load_point(slot, lo + $urandom_range(span), lo + $urandom_range(span));
        end else begin
          r = $urandom_range(99);
          if (limit > 0 && r < 70) begin
            a = $urandom_range(limit - 1);
            b = $urandom_range(limit - 1);
          end else if (limit > 0 && r < 80) begin
            a = $urandom_range(limit - 1);
            b = a;
          end else begin
            a = $urandom_range(255);
            b = $urandom_range(255);
          end
          query_pair(a, b);
        end
      end
    end
  endtask

  initial begin
    int slot;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 9;

    // The count is zero out of reset, so every index is out of range.
    query_pair(0, 0);
    query_pair(255, 255);

    load_point(0, 0, 0);
    load_point(1, 1023, 1023);
    load_point(2, 1023, 0);
    load_point(3, 0, 1023);
    load_point(4, 1023, 1023);
    load_point(5, 512, 511);
    set_point_count(6);
    query_pair(0, 1);
    query_pair(1, 4);
    query_pair(2, 2);
    query_pair(2, 3);
    query_pair(0, 2);
    query_pair(2, 5);
    query_pair(5, 6);
    query_pair(6, 0);
    query_pair(0, 255);

    // With three points the corner of the square sits on the circle, not inside it.
    set_point_count(3);
    query_pair(0, 1);
    query_pair(1, 0);
    set_point_count(0);
    query_pair(0, 1);

    // Fill every slot so that any later count only reads written points.
    for (slot = 0; slot < GBE_MAX_POINTS; slot++)
      load_point(slot, $urandom_range(1023), $urandom_range(1023));

    run_phase(9, 17);
    run_phase(78, 17);
    run_phase(0, 17);

    start <= 1'b0;
    do @(negedge clk); while (pending_answers != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d point loads and %0d pair queries under %0d point-count settings.",
             load_total, query_total, settings_total);
    $display("Checked %0d answers, %0d of them reported as Gabriel edges.",
             answers_total, edges_total);
    if (mismatch_total == 0 && pending_answers == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout: run did not finish.");
    $display("Regression FAIL");
    $finish;
  end

endmodule
